@@ hdl/lgmc_pkg.sv @@
// shared types, codes and constants for the lattice-gas update unit
package lgmc_pkg;

  localparam int CMD_W     = 2;
  localparam int COORD_W   = 5;
  localparam int SPECIES_W = 5;
  localparam int DRAW_W    = 16;
  localparam int THR_W     = 17;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam int SIDE_DEFAULT        = 32;
  localparam int MAX_SPECIES_DEFAULT = 22;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_HOLE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SPECIES = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INSERT_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REMOVE_THR = 2'd2;

  // register reset values
  localparam logic [THR_W-1:0] INIT_THR_RESET   = 17'd11140;
  localparam logic [THR_W-1:0] INSERT_THR_RESET = 17'd655;
  localparam logic [THR_W-1:0] REMOVE_THR_RESET = 17'd65536;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
    logic [SPECIES_W-1:0] species;
    logic [DRAW_W-1:0]    draw;
  } req_word_t;

  typedef struct packed {
    logic [SPECIES_W-1:0] site_value;
    logic                 changed;
    logic                 conflict;
    logic [STATUS_W-1:0]  status;
  } rsp_word_t;

  typedef struct packed {
    logic [THR_W-1:0] init_thr;
    logic [THR_W-1:0] insert_thr;
    logic [THR_W-1:0] remove_thr;
  } thr_t;

endpackage

@@ hdl/lgmc_site_mem.sv @@
// lattice site memory, two registered read ports and one write port
module lgmc_site_mem import lgmc_pkg::*; #(
  parameter int AW = 10
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr_a,
  input  logic [AW-1:0]        rd_addr_b,
  output logic [SPECIES_W-1:0] rd_data_a,
  output logic [SPECIES_W-1:0] rd_data_b,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [SPECIES_W-1:0] wr_data
);

  logic [SPECIES_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

@@ hdl/lgmc_nbr.sv @@
// site and neighbour address generation for the kagome sublattices
module lgmc_nbr import lgmc_pkg::*; #(
  parameter int SIDE   = SIDE_DEFAULT,
  parameter int IDX_W  = 5,
  parameter int AW     = 10
) (
  input  logic [COORD_W-1:0] row,
  input  logic [COORD_W-1:0] col,
  output logic [AW-1:0]      site_addr,
  output logic               site_ok,
  output logic [AW-1:0]      nbr_addr [4],
  output logic [3:0]         nbr_ok
);

  localparam logic [COORD_W:0] ONE = (COORD_W+1)'(1);

  logic [COORD_W:0] r0, c0, rm, rp, cm, cp;
  logic             rm_ok, rp_ok, cm_ok, cp_ok;

  function automatic logic [AW-1:0] addr_of(input logic [COORD_W:0] r,
                                            input logic [COORD_W:0] c);
    return {IDX_W'(r), IDX_W'(c)};
  endfunction

  assign r0 = {1'b0, row};
  assign c0 = {1'b0, col};
  assign rm = r0 - ONE;
  assign rp = r0 + ONE;
  assign cm = c0 - ONE;
  assign cp = c0 + ONE;

  // open edges
  assign rm_ok = (row != '0);
  assign cm_ok = (col != '0);
  assign rp_ok = (int'(rp) < SIDE);
  assign cp_ok = (int'(cp) < SIDE);

  assign site_addr = addr_of(r0, c0);
  assign site_ok   = (int'(row) < SIDE) && (int'(col) < SIDE) && !(row[0] && col[0]);

  always_comb begin
    case ({row[0], col[0]})
      2'b01: begin
        // even row, odd column
        nbr_addr[0] = addr_of(r0, cm);  nbr_ok[0] = cm_ok;
        nbr_addr[1] = addr_of(r0, cp);  nbr_ok[1] = cp_ok;
        nbr_addr[2] = addr_of(rm, cp);  nbr_ok[2] = rm_ok && cp_ok;
        nbr_addr[3] = addr_of(rp, cm);  nbr_ok[3] = rp_ok && cm_ok;
      end
      2'b10: begin
        // odd row, even column
        nbr_addr[0] = addr_of(rm, c0);  nbr_ok[0] = rm_ok;
        nbr_addr[1] = addr_of(rp, c0);  nbr_ok[1] = rp_ok;
        nbr_addr[2] = addr_of(rm, cp);  nbr_ok[2] = rm_ok && cp_ok;
        nbr_addr[3] = addr_of(rp, cm);  nbr_ok[3] = rp_ok && cm_ok;
      end
      default: begin
        // even row, even column (holes never use the pattern)
        nbr_addr[0] = addr_of(rm, c0);  nbr_ok[0] = rm_ok;
        nbr_addr[1] = addr_of(rp, c0);  nbr_ok[1] = rp_ok;
        nbr_addr[2] = addr_of(r0, cm);  nbr_ok[2] = cm_ok;
        nbr_addr[3] = addr_of(r0, cp);  nbr_ok[3] = cp_ok;
      end
    endcase
  end

endmodule

@@ hdl/lgmc_seq.sv @@
// read-modify-write sequencer, update decision and result register
module lgmc_seq import lgmc_pkg::*; #(
  parameter int MAX_SPECIES = MAX_SPECIES_DEFAULT,
  parameter int AW          = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_word_t            req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_word_t            rsp,
  input  thr_t                 thr,
  output logic [COORD_W-1:0]   item_row,
  output logic [COORD_W-1:0]   item_col,
  input  logic [AW-1:0]        site_addr,
  input  logic                 site_ok,
  input  logic [AW-1:0]        nbr_addr [4],
  input  logic [3:0]           nbr_ok,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr_a,
  output logic [AW-1:0]        rd_addr_b,
  input  logic [SPECIES_W-1:0] rd_data_a,
  input  logic [SPECIES_W-1:0] rd_data_b,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [SPECIES_W-1:0] wr_data
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RD0   = 6'b000100,
    ST_RD1   = 6'b001000,
    ST_RD2   = 6'b010000,
    ST_EVAL  = 6'b100000
  } seq_state_t;

  seq_state_t           state, state_next;
  logic [AW-1:0]        clr_cnt;
  req_word_t            item;
  logic [SPECIES_W-1:0] old_val, nv0, nv1, nv2;

  logic [SPECIES_W-1:0] v0, v1, v2, v3, k, new_val;
  logic [THR_W-1:0]     draw_x;
  logic                 any_clash, conf, do_wr, eval_fire;
  logic [STATUS_W-1:0]  status;

  assign item_row  = item.row;
  assign item_col  = item.col;
  assign req_stall = (state != ST_IDLE);
  assign eval_fire = (state == ST_EVAL) && (!rsp_valid || !rsp_stall);

  // read schedule: site and four neighbours over the read states RD0, RD1 and RD2
  always_comb begin
    case (state)
      ST_RD0: begin
        rd_addr_a = site_addr;
        rd_addr_b = nbr_addr[0];
      end
      ST_RD1: begin
        rd_addr_a = nbr_addr[1];
        rd_addr_b = nbr_addr[2];
      end
      default: begin
        rd_addr_a = nbr_addr[3];
        rd_addr_b = nbr_addr[3];
      end
    endcase
  end
  assign rd_en = (state == ST_RD0) || (state == ST_RD1) || (state == ST_RD2);

  // last neighbour is taken straight from the read register, which holds in eval
  assign v0 = nbr_ok[0] ? nv0 : '0;
  assign v1 = nbr_ok[1] ? nv1 : '0;
  assign v2 = nbr_ok[2] ? nv2 : '0;
  assign v3 = nbr_ok[3] ? rd_data_a : '0;
  assign k  = item.species;
  assign draw_x = {1'b0, item.draw};

  assign any_clash = ((v0 != '0) && (v0 != k)) || ((v1 != '0) && (v1 != k)) ||
                     ((v2 != '0) && (v2 != k)) || ((v3 != '0) && (v3 != k));

  always_comb begin
    new_val = old_val;
    conf    = 1'b0;
    status  = STATUS_DONE;
    do_wr   = 1'b0;
    if (!site_ok) begin
      new_val = '0;
      status  = STATUS_HOLE;
    end else if (item.command inside {CMD_INIT, CMD_MOVE}) begin
      if (int'(k) > MAX_SPECIES) begin
        status = STATUS_SPECIES;
      end else begin
        conf  = any_clash;
        do_wr = 1'b1;
        if (item.command == CMD_INIT) begin
          new_val = (!any_clash && (draw_x < thr.init_thr)) ? k : '0;
        end else if (old_val == '0) begin
          if (!any_clash && (draw_x < thr.insert_thr)) begin
            new_val = k;
          end
        end else if (k == '0) begin
          if (draw_x < thr.remove_thr) begin
            new_val = '0;
          end
        end else if (!any_clash) begin
          new_val = k;
        end
      end
    end
  end

  // write port: clearing sweep after reset, otherwise write-back
  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else begin
      wr_en   = eval_fire && do_wr;
      wr_addr = site_addr;
      wr_data = new_val;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == '1) state_next = ST_IDLE;
      ST_IDLE:  if (req_valid) state_next = ST_RD0;
      ST_RD0:   state_next = ST_RD1;
      ST_RD1:   state_next = ST_RD2;
      ST_RD2:   state_next = ST_EVAL;
      ST_EVAL:  if (eval_fire) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (eval_fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && req_valid) begin
      item <= req;
    end
    if (state == ST_RD1) begin
      old_val <= rd_data_a;
      nv0     <= rd_data_b;
    end
    if (state == ST_RD2) begin
      nv1 <= rd_data_a;
      nv2 <= rd_data_b;
    end
    if (eval_fire) begin
      rsp.site_value <= new_val;
      rsp.changed    <= site_ok && (new_val != old_val);
      rsp.conflict   <= conf;
      rsp.status     <= status;
    end
  end

endmodule

@@ hdl/lattice_gas_monte_carlo_update_unit.sv @@
// lattice-gas monte carlo update unit, top level
//
//  channel  direction  handshake              word
//  req      in         req_valid / req_stall  req_word_t: command row col species draw
//  rsp      out        rsp_valid / rsp_stall  rsp_word_t: site_value changed conflict status
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data (threshold registers)
//
//  one item at a time: accept, then three read states on the two read ports of
//  the single site memory (site plus four neighbours) and one decide-and-write state
//  after reset a clearing sweep zeroes all 2**(2*ceil(log2(SIDE))) memory words
//  (1024 words at SIDE 32); req_stall stays high throughout, cfg writes are taken
//  a finished word waits in the rsp register while rsp_stall is high; the next item
//  is accepted meanwhile and held at its write-back until the register frees
module lattice_gas_monte_carlo_update_unit import lgmc_pkg::*; #(
  parameter int SIDE        = SIDE_DEFAULT,
  parameter int MAX_SPECIES = MAX_SPECIES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_word_t            req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_word_t            rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  // sites addressed as {row, col}, each ceil(log2(SIDE)) bits
  localparam int IDX_W = $clog2(SIDE);
  localparam int AW    = 2 * IDX_W;

  thr_t                 thr;
  logic [COORD_W-1:0]   item_row, item_col;
  logic [AW-1:0]        site_addr;
  logic                 site_ok;
  logic [AW-1:0]        nbr_addr [4];
  logic [3:0]           nbr_ok;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr_a, rd_addr_b, wr_addr;
  logic [SPECIES_W-1:0] rd_data_a, rd_data_b, wr_data;

  // threshold registers, always writable; index past the list is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.init_thr   <= INIT_THR_RESET;
      thr.insert_thr <= INSERT_THR_RESET;
      thr.remove_thr <= REMOVE_THR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INIT_THR:   thr.init_thr   <= cfg_data;
        REG_INSERT_THR: thr.insert_thr <= cfg_data;
        REG_REMOVE_THR: thr.remove_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // neighbour pattern of the held item's sublattice
  lgmc_nbr #(
    .SIDE  (SIDE),
    .IDX_W (IDX_W),
    .AW    (AW)
  ) u_nbr (
    .row       (item_row),
    .col       (item_col),
    .site_addr (site_addr),
    .site_ok   (site_ok),
    .nbr_addr  (nbr_addr),
    .nbr_ok    (nbr_ok)
  );

  // lattice store
  lgmc_site_mem #(
    .AW (AW)
  ) u_mem (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // sequencer: reads, decision, write-back and result register
  lgmc_seq #(
    .MAX_SPECIES (MAX_SPECIES),
    .AW          (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .thr       (thr),
    .item_row  (item_row),
    .item_col  (item_col),
    .site_addr (site_addr),
    .site_ok   (site_ok),
    .nbr_addr  (nbr_addr),
    .nbr_ok    (nbr_ok),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

endmodule

@@ hdl/lgmc_checker.sv @@
// port-level checks for the lattice-gas update unit, bound to the top level
module lgmc_checker import lgmc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_word_t rsp
);

  // clearing sweep holds off items right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> req_stall)
    else $error("item channel open straight after reset");

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("item accepted while another is in flight");

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result word changed");

  // holes always answer empty and untouched
  a_hole_word: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == STATUS_HOLE)) |->
      ((rsp.site_value == '0) && !rsp.changed && !rsp.conflict))
    else $error("hole answered with a value");

  // an ignored species leaves the site alone
  a_species_word: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == STATUS_SPECIES)) |-> (!rsp.changed && !rsp.conflict))
    else $error("out-of-range species altered the site");

endmodule

bind lattice_gas_monte_carlo_update_unit lgmc_checker u_chk (.*);
